FILE: rtl/ihex_pkg.sv
// Shared types, character codes and digit decode for the Intel HEX record parser.
package ihex_pkg;

  // Parser phase: waiting for a record, one per field of a record, done and error
  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_ADDRESS = 3'd2,
    PH_TYPE    = 3'd3,
    PH_BODY    = 3'd4,
    PH_EOF     = 3'd5,
    PH_DONE    = 3'd6,
    PH_ERROR   = 3'd7
  } phase_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_EOF   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  // Record types
  localparam logic [15:0] REC_DATA = 16'h0000;
  localparam logic [15:0] REC_EOF  = 16'h0001;

  // Character codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  // End-of-file checksum expected
  localparam logic [7:0] EOF_CHECKSUM = 8'hFF;

  // Decoded hex digit: valid flag and value
  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } digit_t;

  // Upper-case hex digit decode
  function automatic digit_t decode_digit(input logic [7:0] c);
    digit_t d;
    logic [7:0] diff;
    d    = '0;
    diff = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      diff    = c - CH_ZERO;
      d.ok    = 1'b1;
      d.value = diff[3:0];
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      diff    = c - CH_UPPER_A + 8'd10;
      d.ok    = 1'b1;
      d.value = diff[3:0];
    end
    return d;
  endfunction

endpackage

FILE: rtl/intel_hex_record_parser_core.sv
// Intel HEX record parser: one character per request in, at most one result out.
//
// Input channel: one raw text character per request (in_valid_i/in_ready_o).
// Output channel: one result per request (out_valid_o/out_ready_i) carrying the
// kind (data byte, record end with checksum, end of file, error), the record's
// address and length, the byte index and the byte value.
// A character is decoded and the parse state updated in the cycle it is taken;
// its result, if any, appears on the output register in the following cycle.
// Throughput is one character per clock, set by the single output register:
// in_ready_o is high whenever that register is empty or is being emptied in the
// same cycle. A stalled receiver holds the result and stops new input only
// while the register is full.
// Reset clears the parse state to the start of a line and empties the output.
// Errors are sticky: after one, every character yields an error result until
// reset. After the end-of-file record, characters are taken and dropped.
module intel_hex_record_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [15:0] record_address_o,
  output logic [7:0]  record_length_o,
  output logic [7:0]  byte_position_o,
  output logic [7:0]  byte_value_o
);

  // Parse state
  ihex_pkg::phase_e phase_q, phase_d;
  logic [1:0]  digit_cnt_q, digit_cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  seen_q, seen_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  ihex_pkg::kind_e kind_q, kind_d;
  logic [15:0] out_addr_q;
  logic [7:0]  out_len_q;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  val_q, val_d;

  logic            accept;
  logic            blank;
  ihex_pkg::digit_t dig;
  logic [15:0]     value;
  logic            last_digit;
  logic            in_field;
  logic            res_valid;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Character decode
  assign blank = (character_i == ihex_pkg::CH_LF) || (character_i == ihex_pkg::CH_CR) ||
                 (character_i == ihex_pkg::CH_TAB) || (character_i == ihex_pkg::CH_SPACE);
  assign dig   = ihex_pkg::decode_digit(character_i);
  assign value = {acc_q[11:0], dig.value};
  assign last_digit = (phase_q == ihex_pkg::PH_ADDRESS) ? (digit_cnt_q == 2'd3)
                                                        : (digit_cnt_q == 2'd1);
  assign in_field = (phase_q == ihex_pkg::PH_LENGTH) || (phase_q == ihex_pkg::PH_ADDRESS) ||
                    (phase_q == ihex_pkg::PH_TYPE) || (phase_q == ihex_pkg::PH_BODY) ||
                    (phase_q == ihex_pkg::PH_EOF);

  // Next parse state
  always_comb begin
    phase_d     = phase_q;
    digit_cnt_d = digit_cnt_q;
    acc_d       = acc_q;
    len_d       = len_q;
    addr_d      = addr_q;
    seen_d      = seen_q;
    if (accept) begin
      unique case (phase_q)
        ihex_pkg::PH_START: begin
          if (character_i == ihex_pkg::CH_COLON) begin
            phase_d     = ihex_pkg::PH_LENGTH;
            digit_cnt_d = 2'd0;
            acc_d       = '0;
          end else if (!blank) begin
            phase_d = ihex_pkg::PH_ERROR;
          end
        end
        ihex_pkg::PH_DONE, ihex_pkg::PH_ERROR: begin
          phase_d = phase_q;
        end
        default: begin
          if (!dig.ok) begin
            phase_d = ihex_pkg::PH_ERROR;
          end else if (!last_digit) begin
            acc_d       = value;
            digit_cnt_d = digit_cnt_q + 2'd1;
          end else begin
            acc_d       = '0;
            digit_cnt_d = 2'd0;
            unique case (phase_q)
              ihex_pkg::PH_LENGTH: begin
                len_d   = value[7:0];
                seen_d  = '0;
                phase_d = ihex_pkg::PH_ADDRESS;
              end
              ihex_pkg::PH_ADDRESS: begin
                addr_d  = value;
                phase_d = ihex_pkg::PH_TYPE;
              end
              ihex_pkg::PH_TYPE: begin
                if (value == ihex_pkg::REC_DATA) begin
                  seen_d  = '0;
                  phase_d = ihex_pkg::PH_BODY;
                end else if (value == ihex_pkg::REC_EOF) begin
                  phase_d = ihex_pkg::PH_EOF;
                end else begin
                  phase_d = ihex_pkg::PH_ERROR;
                end
              end
              ihex_pkg::PH_BODY: begin
                if (seen_q < len_q) begin
                  seen_d = seen_q + 8'd1;
                end else begin
                  phase_d = ihex_pkg::PH_START;
                end
              end
              ihex_pkg::PH_EOF: begin
                phase_d = (value[7:0] == ihex_pkg::EOF_CHECKSUM) ? ihex_pkg::PH_DONE
                                                                 : ihex_pkg::PH_ERROR;
              end
              default: begin
                phase_d = ihex_pkg::PH_ERROR;
              end
            endcase
          end
        end
      endcase
    end
  end

  // Result for the character taken this cycle
  always_comb begin
    res_valid = 1'b0;
    kind_d    = ihex_pkg::KIND_ERROR;
    pos_d     = '0;
    val_d     = '0;
    priority if (phase_q == ihex_pkg::PH_ERROR) begin
      res_valid = 1'b1;
    end else if (phase_q == ihex_pkg::PH_START) begin
      res_valid = !blank && (character_i != ihex_pkg::CH_COLON);
    end else if (in_field && !dig.ok) begin
      res_valid = 1'b1;
    end else if (in_field && last_digit) begin
      unique case (phase_q)
        ihex_pkg::PH_TYPE: begin
          res_valid = (value != ihex_pkg::REC_DATA) && (value != ihex_pkg::REC_EOF);
        end
        ihex_pkg::PH_BODY: begin
          res_valid = 1'b1;
          val_d     = value[7:0];
          if (seen_q < len_q) begin
            kind_d = ihex_pkg::KIND_DATA;
            pos_d  = seen_q;
          end else begin
            kind_d = ihex_pkg::KIND_END;
          end
        end
        ihex_pkg::PH_EOF: begin
          res_valid = 1'b1;
          if (value[7:0] == ihex_pkg::EOF_CHECKSUM) begin
            kind_d = ihex_pkg::KIND_EOF;
            val_d  = ihex_pkg::EOF_CHECKSUM;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end else begin
      res_valid = 1'b0;
    end
  end

  // Output register fills on a result, empties when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ihex_pkg::PH_START;
      digit_cnt_q <= '0;
      acc_q       <= '0;
      len_q       <= '0;
      addr_q      <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      digit_cnt_q <= digit_cnt_d;
      acc_q       <= acc_d;
      len_q       <= len_d;
      addr_q      <= addr_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      kind_q     <= kind_d;
      out_addr_q <= addr_q;
      out_len_q  <= len_q;
      pos_q      <= pos_d;
      val_q      <= val_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign record_address_o = out_addr_q;
  assign record_length_o  = out_len_q;
  assign byte_position_o  = pos_q;
  assign byte_value_o     = val_q;

endmodule

FILE: rtl/ihex_checker.sv
// Port-level checks for the Intel HEX record parser, bound to the top level.
module ihex_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_o,
  input logic [15:0] record_address_o,
  input logic [7:0]  record_length_o,
  input logic [7:0]  byte_position_o,
  input logic [7:0]  byte_value_o
);

  // A stalled result holds its kind, address, byte index and value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o) &&
      $stable(record_address_o) && $stable(byte_value_o) && $stable(byte_position_o))
    else $error("stalled result changed");

  // An empty output register never blocks input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // Data byte index stays inside the record
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == ihex_pkg::KIND_DATA) |-> byte_position_o < record_length_o)
    else $error("byte index beyond record length");

  // Nothing follows end of file
  a_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (result_kind_o == ihex_pkg::KIND_EOF) |=> !out_valid_o)
    else $error("result after end of file");

  // Errors are sticky
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (result_kind_o == ihex_pkg::KIND_ERROR) && in_valid_i
      |=> out_valid_o && (result_kind_o == ihex_pkg::KIND_ERROR))
    else $error("error did not persist");

endmodule

bind intel_hex_record_parser_core ihex_checker u_ihex_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .result_kind_o    (result_kind_o),
  .record_address_o (record_address_o),
  .record_length_o  (record_length_o),
  .byte_position_o  (byte_position_o),
  .byte_value_o     (byte_value_o)
);

FILE: tb/tb.sv
// Self-checking testbench for the Intel HEX record parser core.
module tb;

  localparam int HOLD_CYCLES     = 80;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 10;

  // One parsed result as seen on the output channel
  typedef struct packed {
    ihex_pkg::kind_e kind;
    logic [15:0]     addr;
    logic [7:0]      len;
    logic [7:0]      pos;
    logic [7:0]      val;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  character = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  result_kind;
  logic [15:0] record_address;
  logic [7:0]  record_length;
  logic [7:0]  byte_position;
  logic [7:0]  byte_value;

  // Parser state mirrored by the predictor
  ihex_pkg::phase_e ph = ihex_pkg::PH_START;
  logic [1:0]  dcnt = '0;
  logic [15:0] acc = '0;
  logic [7:0]  cur_len = '0;
  logic [15:0] cur_addr = '0;
  logic [7:0]  seen = '0;

  result_t     expected_results[$];
  logic [7:0]  line_buf[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int fail_count    = 0;
  int chars_sent    = 0;
  int records_sent  = 0;
  int results_seen  = 0;
  string terminal_case = "none";

  intel_hex_record_parser_core u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .character_i      (character),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .result_kind_o    (result_kind),
    .record_address_o (record_address),
    .record_length_o  (record_length),
    .byte_position_o  (byte_position),
    .byte_value_o     (byte_value)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Upper-case hex decode; bit 4 set means not a digit
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] tmp;
    if (c >= ihex_pkg::CH_ZERO && c <= ihex_pkg::CH_NINE) begin
      tmp = c - ihex_pkg::CH_ZERO;
      return {1'b0, tmp[3:0]};
    end
    if (c >= ihex_pkg::CH_UPPER_A && c <= ihex_pkg::CH_UPPER_F) begin
      tmp = c - ihex_pkg::CH_UPPER_A + 8'd10;
      return {1'b0, tmp[3:0]};
    end
    return 5'h10;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return ihex_pkg::CH_ZERO + 8'(nib);
    return ihex_pkg::CH_UPPER_A + 8'(nib) - 8'd10;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == ihex_pkg::CH_LF || c == ihex_pkg::CH_CR || c == ihex_pkg::CH_TAB ||
           c == ihex_pkg::CH_SPACE;
  endfunction

  task automatic push_result(input ihex_pkg::kind_e k, input logic [7:0] pos,
                             input logic [7:0] v);
    result_t r;
    r.kind = k;
    r.addr = cur_addr;
    r.len  = cur_len;
    r.pos  = pos;
    r.val  = v;
    expected_results.push_back(r);
  endtask

  task automatic raise_error();
    ph = ihex_pkg::PH_ERROR;
    push_result(ihex_pkg::KIND_ERROR, 8'h00, 8'h00);
  endtask

  // Advance the parser by one accepted character
  task automatic predict_char(input logic [7:0] c);
    logic [4:0]  d;
    logic [15:0] val;
    int          need;
    case (ph)
      ihex_pkg::PH_DONE: return;
      ihex_pkg::PH_ERROR: begin
        raise_error();
        return;
      end
      ihex_pkg::PH_START: begin
        if (is_blank(c)) return;
        if (c == ihex_pkg::CH_COLON) begin
          ph   = ihex_pkg::PH_LENGTH;
          dcnt = '0;
          acc  = '0;
          return;
        end
        raise_error();
        return;
      end
      default: ;
    endcase
    d = digit_of(c);
    if (d[4]) begin
      raise_error();
      return;
    end
    acc  = {acc[11:0], d[3:0]};
    need = (ph == ihex_pkg::PH_ADDRESS) ? 4 : 2;
    if (int'(dcnt) + 1 < need) begin
      dcnt = dcnt + 2'd1;
      return;
    end
    val  = acc;
    dcnt = '0;
    acc  = '0;
    case (ph)
      ihex_pkg::PH_LENGTH: begin
        cur_len = val[7:0];
        seen    = '0;
        ph      = ihex_pkg::PH_ADDRESS;
      end
      ihex_pkg::PH_ADDRESS: begin
        cur_addr = val;
        ph       = ihex_pkg::PH_TYPE;
      end
      ihex_pkg::PH_TYPE: begin
        if (val == ihex_pkg::REC_DATA) begin
          seen = '0;
          ph   = ihex_pkg::PH_BODY;
        end else if (val == ihex_pkg::REC_EOF) begin
          ph = ihex_pkg::PH_EOF;
        end else begin
          raise_error();
        end
      end
      ihex_pkg::PH_BODY: begin
        if (seen < cur_len) begin
          push_result(ihex_pkg::KIND_DATA, seen, val[7:0]);
          seen = seen + 8'd1;
        end else begin
          ph = ihex_pkg::PH_START;
          push_result(ihex_pkg::KIND_END, 8'h00, val[7:0]);
        end
      end
      ihex_pkg::PH_EOF: begin
        if (val[7:0] == ihex_pkg::EOF_CHECKSUM) begin
          ph = ihex_pkg::PH_DONE;
          push_result(ihex_pkg::KIND_EOF, 8'h00, ihex_pkg::EOF_CHECKSUM);
        end else begin
          raise_error();
        end
      end
      default: raise_error();
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Send one request, with random idle cycles ahead of it
  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    character <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_char(c);
    chars_sent++;
  endtask

  task automatic put_char(input logic [7:0] c);
    line_buf.push_back(c);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  task automatic put_hex(input logic [15:0] v, input int nd);
    for (int i = nd - 1; i >= 0; i--) put_char(hex_char(v[4*i +: 4]));
  endtask

  task automatic put_blank();
    case ($urandom_range(0, 3))
      0:       put_char(ihex_pkg::CH_LF);
      1:       put_char(ihex_pkg::CH_CR);
      2:       put_char(ihex_pkg::CH_TAB);
      default: put_char(ihex_pkg::CH_SPACE);
    endcase
  endtask

  // Data record with random bytes; checksum right or random, as it is not checked
  task automatic put_data_record(input logic [7:0] len, input logic [15:0] addr);
    logic [7:0] sum;
    logic [7:0] b;
    sum = len + addr[15:8] + addr[7:0];
    put_char(ihex_pkg::CH_COLON);
    put_hex(16'(len), 2);
    put_hex(addr, 4);
    put_hex(ihex_pkg::REC_DATA, 2);
    for (int i = 0; i < int'(len); i++) begin
      b   = 8'($urandom);
      sum = sum + b;
      put_hex(16'(b), 2);
    end
    if ($urandom_range(0, 1) == 1) put_hex(16'(8'(-sum)), 2);
    else put_hex(16'($urandom_range(0, 255)), 2);
    records_sent++;
  endtask

  task automatic send_buf();
    while (line_buf.size() != 0) send_char(line_buf.pop_front());
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Receiver: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
    if (a !== e) begin
      $display("%0t: %s expected %h actual %h", $time, name, e, a);
      fail_count++;
    end
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result expected none actual kind %0d addr %h len %h pos %h val %h",
                 $time, result_kind, record_address, record_length, byte_position,
                 byte_value);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", 16'(want.kind), 16'(result_kind));
        check_field("record_address", want.addr, record_address);
        check_field("record_length", 16'(want.len), 16'(record_length));
        check_field("byte_position", 16'(want.pos), 16'(byte_position));
        check_field("byte_value", 16'(want.val), 16'(byte_value));
        results_seen++;
      end
    end
  end

  // Watchdog on cycles with no request moving on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_CYCLES);
    $display("intel_hex_record_parser_core: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Blanks, empty record at the top address, data extremes at address zero
  task automatic test_directed();
    send_idle_pct = 22;
    recv_idle_pct = 76;
    put_char(ihex_pkg::CH_LF);
    put_char(ihex_pkg::CH_CR);
    put_char(ihex_pkg::CH_TAB);
    put_char(ihex_pkg::CH_SPACE);
    put_text(":00FFFF00FF");
    put_char(ihex_pkg::CH_CR);
    put_char(ihex_pkg::CH_LF);
    put_text(":0200000000FFA5");
    put_char(ihex_pkg::CH_LF);
    records_sent += 2;
    send_buf();
  endtask

  // Data records, mostly short, with blanks in between; checksums right or random
  task automatic test_random_records(input int send_pct, input int recv_pct, input int budget);
    int         first;
    logic [7:0] len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first = chars_sent;
    while (chars_sent - first < budget) begin
      if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(7, 24));
      else len = 8'($urandom_range(0, 6));
      put_data_record(len, 16'($urandom));
      repeat ($urandom_range(0, 3)) put_blank();
      send_buf();
    end
  endtask

  // One long record, so byte indexes well past the short records are reached
  task automatic test_long_record();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    put_data_record(8'h80, 16'($urandom));
    put_char(ihex_pkg::CH_LF);
    send_buf();
  endtask

  // Receiver holds off while records keep coming; then the sender waits for all results
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repeat (3) begin
      put_data_record(8'($urandom_range(4, 6)), 16'($urandom));
      put_blank();
      send_buf();
    end
    wait_drained();
  endtask

  // One way of ending the parse, chosen at random, then raw noise
  task automatic test_terminal();
    logic [7:0] c;
    logic [4:0] dv;
    int         p;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    case ($urandom_range(0, 4))
      0: begin
        terminal_case = "stray character";
        do c = 8'($urandom); while (is_blank(c) || c == ihex_pkg::CH_COLON);
        put_char(c);
      end
      1: begin
        terminal_case = "bad digit";
        put_data_record(8'($urandom_range(1, 3)), 16'($urandom));
        p = $urandom_range(1, line_buf.size() - 1);
        while (line_buf.size() > p) void'(line_buf.pop_back());
        if ($urandom_range(0, 1) == 1) c = "a" + 8'($urandom_range(0, 5));
        else begin
          do begin
            c  = 8'($urandom);
            dv = digit_of(c);
          end while (!dv[4]);
        end
        put_char(c);
      end
      2: begin
        terminal_case = "unknown record type";
        put_char(ihex_pkg::CH_COLON);
        put_hex(16'($urandom_range(0, 255)), 2);
        put_hex(16'($urandom), 4);
        put_hex(16'($urandom_range(2, 255)), 2);
        records_sent++;
      end
      3: begin
        terminal_case = "bad end-of-file checksum";
        put_char(ihex_pkg::CH_COLON);
        put_hex(16'($urandom_range(0, 255)), 2);
        put_hex(16'($urandom), 4);
        put_hex(ihex_pkg::REC_EOF, 2);
        put_hex(16'($urandom_range(0, 254)), 2);
        records_sent++;
      end
      default: begin
        terminal_case = "end of file";
        put_char(ihex_pkg::CH_COLON);
        put_hex(16'($urandom_range(0, 255)), 2);
        put_hex(16'($urandom), 4);
        put_hex(ihex_pkg::REC_EOF, 2);
        put_hex(16'(ihex_pkg::EOF_CHECKSUM), 2);
        records_sent++;
      end
    endcase
    // Noise: sticky errors, or ignored after end of file
    put_char(8'h00);
    put_char(8'hFF);
    repeat (38) put_char(8'($urandom));
    send_buf();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_records(22, 76, 50);
    test_random_records(76, 22, 50);
    test_long_record();
    test_random_records(0, 0, 20);
    test_backpressure();
    test_terminal();

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d characters in %0d records, %0d results checked",
             chars_sent, records_sent, results_seen);
    $display("parse ended by: %s, %0d mismatches", terminal_case, fail_count);
    if (fail_count == 0) $display("intel_hex_record_parser_core: match");
    else $display("intel_hex_record_parser_core: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
rtl/ihex_pkg.sv
rtl/intel_hex_record_parser_core.sv
rtl/ihex_checker.sv
tb/tb.sv
